[rtl/core/sba_pkg.sv]
package sba_pkg;

    // Field widths
    localparam int KIND_W     = 1;
    localparam int COUNT_W    = 16;
    localparam int IDX_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int START_W    = 26;
    localparam int STATUS_W   = 2;
    localparam int ACTIVE_W   = 13;
    localparam int SECTOR_W   = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SECTOR = 8'd1;

    // Reset values of the configuration registers
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 13'd4096;
    localparam logic [SECTOR_W-1:0] SECTOR_RESET = 24'd1;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic load_wr;
        logic fetch;
        logic eval;
        logic finish;
        logic out_push;
    } sba_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic eval_stop;
        logic out_free;
    } sba_stat_t;

endpackage

[rtl/core/sector_bitmap_allocator_unit.sv]
// Channel   Ports                                          Direction
// s_        s_valid s_ready s_kind s_count s_byte_index    in  (request)
//           s_byte_value
// m_        m_valid m_ready m_start_sector m_status        out (result)
// cfg_      cfg_valid cfg_ready cfg_index cfg_data         in  (register write)
//
// Load: the byte is written to the bitmap, then the result is pushed to the output.
// Allocate: each bitmap byte scanned takes a registered read, then mark and write back;
// when the count is met or the scan runs off the active bytes, a finish step forms
// the result. After reset s_ready stays low through a clearing pass of all
// MAP_BYTES bitmap bytes; register writes are taken throughout.
// A stalled result holds in the output register; the next request's result waits on it.
module sector_bitmap_allocator_unit #(
    parameter int MAP_BYTES = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sba_pkg::KIND_W-1:0]           s_kind,
    input  logic [sba_pkg::COUNT_W-1:0]          s_count,
    input  logic [sba_pkg::IDX_W-1:0]            s_byte_index,
    input  logic [sba_pkg::BYTE_W-1:0]           s_byte_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sba_pkg::START_W-1:0]   m_start_sector,
    output logic [sba_pkg::STATUS_W-1:0]         m_status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sba_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [sba_pkg::ACTIVE_W-1:0] active_bytes_reg;
    logic [sba_pkg::SECTOR_W-1:0] first_sector_reg;
    sba_pkg::sba_cmd_t            cmd;
    sba_pkg::sba_stat_t           stat;

    assign cfg_ready = 1'b1;

    // Decode register writes; drop indexes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_bytes_reg <= sba_pkg::ACTIVE_RESET;
            first_sector_reg <= sba_pkg::SECTOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sba_pkg::CFG_ACTIVE_BYTES: active_bytes_reg <= cfg_data[sba_pkg::ACTIVE_W-1:0];
                sba_pkg::CFG_FIRST_SECTOR: first_sector_reg <= cfg_data[sba_pkg::SECTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind[0]),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sba_datapath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_count        (s_count),
        .s_byte_index   (s_byte_index),
        .s_byte_value   (s_byte_value),
        .active_bytes   (active_bytes_reg),
        .first_sector   (first_sector_reg),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_start_sector (m_start_sector),
        .m_status       (m_status)
    );

endmodule

[rtl/core/sba_ctrl.sv]
module sba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_kind,
    output logic              s_ready,
    input  sba_pkg::sba_stat_t stat,
    output sba_pkg::sba_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequence clear, load, scan and result delivery
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_kind == sba_pkg::KIND_LOAD) ? ST_LOAD : ST_FETCH;
                end
            end
            ST_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_FETCH: begin
                if (stat.scan_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = stat.eval_stop ? ST_FINISH : ST_FETCH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/sba_datapath.sv]
module sba_datapath #(
    parameter int MAP_BYTES = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sba_pkg::sba_cmd_t                    cmd,
    output sba_pkg::sba_stat_t                   stat,
    input  logic [sba_pkg::COUNT_W-1:0]          s_count,
    input  logic [sba_pkg::IDX_W-1:0]            s_byte_index,
    input  logic [sba_pkg::BYTE_W-1:0]           s_byte_value,
    input  logic [sba_pkg::ACTIVE_W-1:0]         active_bytes,
    input  logic [sba_pkg::SECTOR_W-1:0]         first_sector,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [sba_pkg::START_W-1:0]   m_start_sector,
    output logic [sba_pkg::STATUS_W-1:0]         m_status
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = $clog2(MAP_BYTES + 1);
    localparam int LW = (CW > sba_pkg::ACTIVE_W) ? CW : sba_pkg::ACTIVE_W;
    localparam int FW = LW + 3;

    logic [sba_pkg::BYTE_W-1:0] mem [MAP_BYTES];

    logic [AW-1:0]                   clr_addr_reg;
    logic [sba_pkg::COUNT_W-1:0]     rem_reg;
    logic [sba_pkg::IDX_W-1:0]       idx_reg;
    logic [sba_pkg::BYTE_W-1:0]      val_reg;
    logic [LW-1:0]                   j_reg;
    logic                            found_reg;
    logic [FW-1:0]                   first_bit_reg;
    logic [sba_pkg::BYTE_W-1:0]      rd_data_reg;
    logic [sba_pkg::START_W-1:0]     res_start_reg;
    logic [sba_pkg::STATUS_W-1:0]    res_status_reg;
    logic                            m_valid_reg;
    logic [sba_pkg::START_W-1:0]     m_start_reg;
    logic [sba_pkg::STATUS_W-1:0]    m_status_reg;

    logic [LW-1:0]                   limit;
    logic                            we;
    logic [AW-1:0]                   wa;
    logic [sba_pkg::BYTE_W-1:0]      wd;
    logic [sba_pkg::BYTE_W-1:0]      b_new;
    logic [3:0]                      take;
    logic [3:0]                      taken;
    logic [2:0]                      low_k;
    logic                            has_free;
    logic                            found_next;
    logic [sba_pkg::COUNT_W-1:0]     rem_next;
    logic [sba_pkg::START_W-1:0]     start_sum;

    // Clip the active byte count to the map size
    always_comb begin
        if (LW'(active_bytes) > LW'(MAP_BYTES)) begin
            limit = LW'(MAP_BYTES);
        end else begin
            limit = LW'(active_bytes);
        end
    end

    // Mark the lowest free bits of the fetched byte, at most the remaining count
    always_comb begin
        take = (rem_reg >= sba_pkg::COUNT_W'(8)) ? 4'd8 : rem_reg[3:0];
        taken = 4'd0;
        b_new = rd_data_reg;
        for (int k = 0; k < sba_pkg::BYTE_W; k++) begin
            if (!rd_data_reg[k] && (taken < take)) begin
                b_new[k] = 1'b1;
                taken    = taken + 4'd1;
            end
        end
        low_k = 3'd0;
        for (int k = sba_pkg::BYTE_W - 1; k >= 0; k--) begin
            if (!rd_data_reg[k]) begin
                low_k = 3'(k);
            end
        end
        has_free   = (rd_data_reg != sba_pkg::BYTE_FULL);
        found_next = found_reg | has_free;
        rem_next   = rem_reg - sba_pkg::COUNT_W'(taken);
    end

    assign start_sum = sba_pkg::START_W'(first_bit_reg) + sba_pkg::START_W'(first_sector)
                     - sba_pkg::START_W'(1);

    assign stat.clr_last  = (clr_addr_reg == AW'(MAP_BYTES - 1));
    assign stat.scan_end  = (j_reg >= limit);
    assign stat.eval_stop = found_next && (rem_next == '0);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Select the memory write: clearing pass, load, or scan write-back
    always_comb begin
        we = 1'b0;
        wa = clr_addr_reg;
        wd = '0;
        if (cmd.clr_step) begin
            we = 1'b1;
        end else if (cmd.load_wr) begin
            we = (32'(idx_reg) < MAP_BYTES);
            wa = AW'(idx_reg);
            wd = val_reg;
        end else if (cmd.eval) begin
            we = 1'b1;
            wa = j_reg[AW-1:0];
            wd = b_new;
        end
    end

    // Bitmap memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[j_reg[AW-1:0]];
        end
    end

    // Step the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Hold the request and the scan state
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rem_reg   <= s_count;
            idx_reg   <= s_byte_index;
            val_reg   <= s_byte_value;
            j_reg     <= '0;
            found_reg <= 1'b0;
        end else if (cmd.eval) begin
            rem_reg   <= rem_next;
            j_reg     <= j_reg + LW'(1);
            found_reg <= found_next;
            if (!found_reg && has_free) begin
                first_bit_reg <= {j_reg, low_k};
            end
        end
    end

    // Form the result
    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            res_start_reg  <= '0;
            res_status_reg <= sba_pkg::STATUS_LOADED;
        end else if (cmd.finish) begin
            res_start_reg  <= found_reg ? start_sum : '0;
            res_status_reg <= (rem_reg == '0) ? sba_pkg::STATUS_OK : sba_pkg::STATUS_SHORT;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_push) begin
            m_start_reg  <= res_start_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_start_sector = $signed(m_start_reg);
    assign m_status       = m_status_reg;

    a_eval_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |-> $past(cmd.fetch))
        else $error("byte evaluated without a fetch");

    a_rem_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |=> (rem_reg <= $past(rem_reg)))
        else $error("remaining count grew during scan");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_push |-> stat.out_free)
        else $error("result pushed into an occupied output register");

    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == sba_pkg::STATUS_LOADED) |-> (m_start_reg == '0))
        else $error("load result carries a nonzero start sector");

endmodule
